### hw/rtl/cwrc_pkg.sv
`timescale 1ns / 1ps

package cwrc_pkg;

    // window limits, in packets
    localparam int unsigned INIT_WIN = 10;
    localparam int unsigned MIN_WIN  = 2;
    localparam int unsigned MAX_WIN  = 1024;

    localparam int unsigned WIN_W   = 12;
    localparam int unsigned THR_W   = 11;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned PRIO_W  = 2;
    localparam int unsigned RTT_W   = 32;
    localparam int unsigned TO_W    = 13;
    localparam int unsigned ACK_W   = 64;
    localparam int unsigned DCNT_W  = $clog2(ACK_W);
    localparam int unsigned SUM_W   = RTT_W + 3;
    localparam int unsigned RTO_W   = 23;
    localparam int unsigned RCP_W   = 24;
    localparam int unsigned RCP_SH  = 33;
    localparam int unsigned OUT_W   = 40;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ACK_W - 1);

    // window caps per priority
    localparam logic [WIN_W-1:0] CAP_NORM = WIN_W'(MAX_WIN);
    localparam logic [WIN_W-1:0] CAP_HIGH = WIN_W'((MAX_WIN * 3) / 2);
    localparam logic [WIN_W-1:0] CAP_CRIT = WIN_W'(MAX_WIN * 2);

    localparam logic [WIN_W-1:0] INIT_CWND = WIN_W'(INIT_WIN);
    localparam logic [THR_W-1:0] INIT_THR  = THR_W'(MAX_WIN / 2);
    localparam logic [THR_W-1:0] MIN_THR   = THR_W'(MIN_WIN);
    localparam logic [WIN_W-1:0] MIN_CWND  = WIN_W'(MIN_WIN);

    // retry timeout limits in us, and in ms
    localparam logic [RTO_W-1:0] RTO_MIN_US = RTO_W'(200000);
    localparam logic [RTO_W-1:0] RTO_MAX_US = RTO_W'(5000000);
    localparam logic [TO_W-1:0]  TO_MIN_MS  = TO_W'(200);
    localparam logic [TO_W-1:0]  TO_MAX_MS  = TO_W'(5000);
    localparam logic [TO_W-1:0]  TO_DEF_MS  = TO_W'(1000);
    // ceil(2^33 / 1000), exact for every value below 2^24
    localparam logic [RCP_W-1:0] RECIP_1000 = RCP_W'(8589935);

    // phase codes
    localparam logic [MODE_W-1:0] PH_SLOW  = 2'd0;
    localparam logic [MODE_W-1:0] PH_AVOID = 2'd1;
    localparam logic [MODE_W-1:0] PH_RECOV = 2'd2;

    // event codes
    localparam logic [FUNC_W-1:0] EV_ACK  = 2'd0;
    localparam logic [FUNC_W-1:0] EV_LOSS = 2'd1;
    localparam logic [FUNC_W-1:0] EV_RTT  = 2'd2;

    // priority codes
    localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_CRIT = 2'd2;

    typedef struct packed {
        logic load;
        logic apply;
        logic div_step;
        logic div_end;
        logic to_sum;
        logic to_scale;
        logic to_conv;
        logic out_load;
    } cwrc_cmd_t;

    typedef struct packed {
        logic div_needed;
    } cwrc_stat_t;

endpackage

### hw/rtl/cwrc_ctrl.sv
`timescale 1ns / 1ps

module cwrc_ctrl
    import cwrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  cwrc_stat_t stat,
    output cwrc_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVENT  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_DIVEND = 3'd3;
    localparam logic [2:0] S_TSUM   = 3'd4;
    localparam logic [2:0] S_TSCALE = 3'd5;
    localparam logic [2:0] S_TCONV  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVENT;
                end
            end
            S_EVENT:
            begin
                cmd.apply  = 1'b1;
                cnt_next   = '0;
                state_next = stat.div_needed ? S_DIV : S_TSUM;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND:
            begin
                cmd.div_end = 1'b1;
                state_next  = S_TSUM;
            end
            S_TSUM:
            begin
                cmd.to_sum = 1'b1;
                state_next = S_TSCALE;
            end
            S_TSCALE:
            begin
                cmd.to_scale = 1'b1;
                state_next   = S_TCONV;
            end
            S_TCONV:
            begin
                cmd.to_conv = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        else
        begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

### hw/rtl/cwrc_dp.sv
`timescale 1ns / 1ps

module cwrc_dp
    import cwrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cwrc_cmd_t         cmd,
    output cwrc_stat_t        stat,
    input  logic [RTT_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0] s_tuser,
    input  logic              cfg_valid,
    input  logic [PRIO_W-1:0] cfg_data,
    output logic [OUT_W-1:0]  m_tdata
);

    logic [FUNC_W-1:0] func_reg;
    logic [RTT_W-1:0]  rtt_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [WIN_W-1:0]  cwnd_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [ACK_W-1:0]  ack_reg;
    logic [RTT_W-1:0]  srtt_reg;
    logic [RTT_W-1:0]  var_reg;
    logic [ACK_W-1:0]  divq_reg;
    logic [WIN_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rto_sum_reg;
    logic [RTO_W-1:0]  rto_clamp_reg;
    logic [TO_W-1:0]   timeout_reg;
    logic [OUT_W-1:0]  out_reg;

    logic [WIN_W-1:0]       cap;
    logic [WIN_W:0]         win_inc;
    logic [WIN_W-1:0]       grown;
    logic [THR_W-1:0]       loss_thr;
    logic [WIN_W+1:0]       win_x3;
    logic [WIN_W-1:0]       recov_win;
    logic [ACK_W-1:0]       ack_inc;
    logic [RTT_W-1:0]       rtt_diff;
    logic [RTT_W+1:0]       var_sum;
    logic [SUM_W-1:0]       srtt_sum;
    logic [WIN_W-1:0]       trial;
    logic                   trial_ge;
    logic [WIN_W-1:0]       rem_next;
    logic [SUM_W+1:0]       sum_x3;
    logic [SUM_W-1:0]       rto_scaled;
    logic [RTO_W-1:0]       rto_clamped;
    logic [RTO_W+RCP_W-1:0] prod;

    // window cap follows priority, unused code acts as normal
    always_comb
    begin
        case (prio_reg)
            PRIO_HIGH: cap = CAP_HIGH;
            PRIO_CRIT: cap = CAP_CRIT;
            default:   cap = CAP_NORM;
        endcase
    end

    assign win_inc  = {1'b0, cwnd_reg} + 1'b1;
    assign grown    = (win_inc < {1'b0, cap}) ? win_inc[WIN_W-1:0] : cap;
    assign loss_thr = (cwnd_reg[WIN_W-1:1] < MIN_THR) ? MIN_THR : cwnd_reg[WIN_W-1:1];
    assign win_x3   = {2'b00, cwnd_reg} + {1'b0, cwnd_reg, 1'b0};
    assign recov_win = (win_x3[WIN_W+1:2] < MIN_CWND) ? MIN_CWND : win_x3[WIN_W+1:2];
    assign ack_inc  = ack_reg + 1'b1;

    // rtt estimator
    assign rtt_diff = (rtt_reg >= srtt_reg) ? (rtt_reg - srtt_reg) : (srtt_reg - rtt_reg);
    assign var_sum  = {2'b00, var_reg} + {1'b0, var_reg, 1'b0} + {2'b00, rtt_diff};
    assign srtt_sum = {srtt_reg, 3'b000} - {3'b000, srtt_reg} + {3'b000, rtt_reg};

    // one restoring remainder step
    assign trial    = {rem_reg[WIN_W-2:0], divq_reg[ACK_W-1]};
    assign trial_ge = (trial >= cwnd_reg);
    assign rem_next = trial_ge ? (trial - cwnd_reg) : trial;

    assign stat.div_needed = (func_reg == EV_ACK) && (mode_reg == PH_AVOID)
                             && (cwnd_reg != '0);

    // timeout scaling and clamping
    assign sum_x3 = {2'b00, rto_sum_reg} + {1'b0, rto_sum_reg, 1'b0};
    always_comb
    begin
        case (prio_reg)
            PRIO_HIGH: rto_scaled = sum_x3[SUM_W+1:2];
            PRIO_CRIT: rto_scaled = {1'b0, rto_sum_reg[SUM_W-1:1]};
            default:   rto_scaled = rto_sum_reg;
        endcase
        if (rto_scaled < SUM_W'(RTO_MIN_US))
        begin
            rto_clamped = RTO_MIN_US;
        end
        else if (rto_scaled > SUM_W'(RTO_MAX_US))
        begin
            rto_clamped = RTO_MAX_US;
        end
        else
        begin
            rto_clamped = rto_scaled[RTO_W-1:0];
        end
    end

    assign prod = {{RCP_W{1'b0}}, rto_clamp_reg} * {{RTO_W{1'b0}}, RECIP_1000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg <= '0;
            cwnd_reg <= INIT_CWND;
            thr_reg  <= INIT_THR;
            mode_reg <= PH_SLOW;
            ack_reg  <= '0;
            srtt_reg <= '0;
            var_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                prio_reg <= cfg_data;
            end
            if (cmd.apply)
            begin
                case (func_reg)
                    EV_ACK:
                    begin
                        ack_reg <= ack_inc;
                        case (mode_reg)
                            PH_SLOW:
                            begin
                                cwnd_reg <= grown;
                                if (cwnd_reg >= {1'b0, thr_reg})
                                begin
                                    mode_reg <= PH_AVOID;
                                end
                            end
                            PH_RECOV:
                            begin
                                mode_reg <= PH_AVOID;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    EV_LOSS:
                    begin
                        case (mode_reg)
                            PH_SLOW, PH_AVOID:
                            begin
                                thr_reg  <= loss_thr;
                                cwnd_reg <= {1'b0, loss_thr};
                                mode_reg <= PH_RECOV;
                            end
                            PH_RECOV:
                            begin
                                cwnd_reg <= recov_win;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    EV_RTT:
                    begin
                        if (srtt_reg == '0)
                        begin
                            srtt_reg <= rtt_reg;
                            var_reg  <= {1'b0, rtt_reg[RTT_W-1:1]};
                        end
                        else
                        begin
                            srtt_reg <= srtt_sum[SUM_W-1:3];
                            var_reg  <= var_sum[RTT_W+1:2];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // grow once per window of acks
            if (cmd.div_end && (rem_reg == '0))
            begin
                cwnd_reg <= grown;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            rtt_reg  <= s_tdata;
        end
        if (cmd.apply)
        begin
            divq_reg <= ack_inc;
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            divq_reg <= {divq_reg[ACK_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
        if (cmd.to_sum)
        begin
            rto_sum_reg <= {3'b000, srtt_reg} + {1'b0, var_reg, 2'b00};
        end
        if (cmd.to_scale)
        begin
            rto_clamp_reg <= rto_clamped;
        end
        if (cmd.to_conv)
        begin
            timeout_reg <= (srtt_reg == '0) ? TO_DEF_MS : prod[RCP_SH+TO_W-1:RCP_SH];
        end
        if (cmd.out_load)
        begin
            out_reg <= {2'b00, timeout_reg, mode_reg, thr_reg, cwnd_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

### hw/rtl/congestion_window_and_rto_controller_unit.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tuser: event kind, s_tdata: rtt in us
// m_*       out  m_tvalid/m_tready    m_tdata: window, threshold, phase, timeout
// cfg_*     in   cfg_valid/cfg_ready  cfg_data: priority level
//
// the result register loads after the apply, timeout sum, scale and convert states, once
// the output register is free; for an ack in congestion avoidance the 64-bit ack count is
// first reduced modulo the window one bit per cycle by a restoring remainder step in the
// datapath, and s_tready returns the cycle after the result register loads
// rst_n clears window state, estimator and priority asynchronously
// one item at a time: s_tready is high only while the sequencer is idle
// a finished result waits in the output register while the next item is taken

module congestion_window_and_rto_controller_unit
    import cwrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [RTT_W-1:0]  s_tdata,   // [31:0] rtt_us
    input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [11:0] window, [22:12] slow_start_limit,
                                         // [24:23] phase, [37:25] timeout_ms, rest zero
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PRIO_W-1:0] cfg_data   // [1:0] priority_level
);

    cwrc_cmd_t  cmd;
    cwrc_stat_t stat;

    // priority register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, apply event, optional remainder loop, timeout steps
    cwrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // window state, rtt estimator, remainder unit, timeout conversion
    cwrc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

    // busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while item in flight");

    // datapath commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // reported timeout stays in its clamp range
    a_timeout_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[37:25] >= TO_MIN_MS) && (m_tdata[37:25] <= TO_MAX_MS))
        else $error("timeout out of range");

    // window never reported as zero
    a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:0] != '0))
        else $error("zero window reported");

endmodule

### tb/congestion_window_and_rto_controller_unit_tb.sv
`timescale 1ns / 1ps

module congestion_window_and_rto_controller_unit_tb;
    import cwrc_pkg::*;

    // codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] EV_NONE    = 2'd3;
    localparam logic [PRIO_W-1:0] PRIO_NORM  = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_ALIAS = 2'd3;

    // bit offsets inside m_tdata
    localparam int THR_LSB  = WIN_W;
    localparam int MODE_LSB = THR_LSB + THR_W;
    localparam int TO_LSB   = MODE_LSB + MODE_W;
    localparam int PAD_LSB  = TO_LSB + TO_W;

    // slowest item is an avoidance ack, which runs the remainder loop
    localparam int SETTLE_CYCLES   = 80;
    localparam int DRAIN_TAIL      = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic [THR_W-1:0]  slow_start_limit;
        logic [MODE_W-1:0] phase;
        logic [TO_W-1:0]   timeout_ms;
    } report_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [RTT_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0] s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [PRIO_W-1:0] cfg_data  = '0;

    // predictor copy of the controller state
    logic [31:0]       win_now     = INIT_WIN;
    logic [31:0]       ssthresh_now = MAX_WIN / 2;
    logic [MODE_W-1:0] phase_now   = PH_SLOW;
    logic [63:0]       acks_seen   = '0;
    logic [31:0]       srtt_now    = '0;
    logic [31:0]       rttvar_now  = '0;
    logic [PRIO_W-1:0] prio_now    = PRIO_NORM;

    // reports predicted at input transfer, oldest first
    report_t due_reports[$];

    int fail_count      = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int hold_len        = 0;
    int hold_req_id     = 0;
    int quiet_cycles    = 0;

    congestion_window_and_rto_controller_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // window cap scales with priority, 3 behaves as normal
    function automatic logic [31:0] win_cap();
        case (prio_now)
            PRIO_HIGH: return (MAX_WIN * 3) / 2;
            PRIO_CRIT: return MAX_WIN * 2;
            default:   return MAX_WIN;
        endcase
    endfunction

    function automatic logic [31:0] grown_window(input logic [31:0] cur);
        logic [31:0] nxt;
        logic [31:0] cap;
        cap = win_cap();
        nxt = cur + 1;
        return (nxt < cap) ? nxt : cap;
    endfunction

    // srtt + 4 * rttvar, scaled, clamped in us, truncated to ms
    function automatic logic [TO_W-1:0] timeout_now();
        logic [63:0] rto;
        if (srtt_now == 0)
            return TO_DEF_MS;
        rto = 64'(srtt_now) + 64'(rttvar_now) * 4;
        if (prio_now == PRIO_HIGH)
            rto = (rto * 3) / 4;
        else if (prio_now == PRIO_CRIT)
            rto = rto / 2;
        if (rto < 64'(RTO_MIN_US))
            rto = 64'(RTO_MIN_US);
        if (rto > 64'(RTO_MAX_US))
            rto = 64'(RTO_MAX_US);
        return TO_W'(rto / 1000);
    endfunction

    // advance the state by one event and return the report it produces
    function automatic report_t apply_event(input logic [FUNC_W-1:0] ev,
                                            input logic [RTT_W-1:0] rtt);
        logic [31:0] cur;
        logic [31:0] v;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] d;
        report_t     rep;
        cur = win_now;
        case (ev)
            EV_ACK:
            begin
                acks_seen = acks_seen + 1;
                if (phase_now == PH_SLOW)
                begin
                    win_now = grown_window(cur);
                    if (cur >= ssthresh_now)
                        phase_now = PH_AVOID;
                end
                else if (phase_now == PH_AVOID)
                begin
                    if (cur != 0 && (acks_seen % 64'(cur)) == 0)
                        win_now = grown_window(cur);
                end
                else if (phase_now == PH_RECOV)
                begin
                    phase_now = PH_AVOID;
                end
            end
            EV_LOSS:
            begin
                if (phase_now == PH_SLOW || phase_now == PH_AVOID)
                begin
                    v = cur / 2;
                    if (v < MIN_WIN)
                        v = MIN_WIN;
                    ssthresh_now = v;
                    win_now = v;
                    phase_now = PH_RECOV;
                end
                else if (phase_now == PH_RECOV)
                begin
                    v = 32'((64'(cur) * 3) / 4);
                    if (v < MIN_WIN)
                        v = MIN_WIN;
                    win_now = v;
                end
            end
            EV_RTT:
            begin
                if (srtt_now == 0)
                begin
                    // first sample, also after a zero first sample
                    srtt_now = rtt;
                    rttvar_now = rtt >> 1;
                end
                else
                begin
                    s = 64'(srtt_now);
                    r = 64'(rtt);
                    d = (r >= s) ? r - s : s - r;
                    rttvar_now = 32'((64'(rttvar_now) * 3 + d) / 4);
                    srtt_now = 32'((s * 7 + r) / 8);
                end
            end
            default:
            begin
                // no event, state holds
            end
        endcase
        rep.window = win_now[WIN_W-1:0];
        rep.slow_start_limit = ssthresh_now[THR_W-1:0];
        rep.phase = phase_now;
        rep.timeout_ms = timeout_now();
        return rep;
    endfunction

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // ready toggles at random, with an occasional long hold-off on request
    always @(negedge clk)
    begin : sink_ready
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_req_id)
        begin
            hold_seen = hold_req_id;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // compare each result transfer against the oldest prediction
    always @(posedge clk)
    begin : check_results
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_reports.size() == 0)
            begin
                $error("result with nothing predicted: m_tdata=%h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = due_reports.pop_front();
                if (m_tdata[0 +: WIN_W] !== want.window)
                begin
                    $error("window: expected %0d, got %0d", want.window, m_tdata[0 +: WIN_W]);
                    fail_count++;
                end
                if (m_tdata[THR_LSB +: THR_W] !== want.slow_start_limit)
                begin
                    $error("slow_start_limit: expected %0d, got %0d",
                           want.slow_start_limit, m_tdata[THR_LSB +: THR_W]);
                    fail_count++;
                end
                if (m_tdata[MODE_LSB +: MODE_W] !== want.phase)
                begin
                    $error("phase: expected %0d, got %0d", want.phase,
                           m_tdata[MODE_LSB +: MODE_W]);
                    fail_count++;
                end
                if (m_tdata[TO_LSB +: TO_W] !== want.timeout_ms)
                begin
                    $error("timeout_ms: expected %0d, got %0d", want.timeout_ms,
                           m_tdata[TO_LSB +: TO_W]);
                    fail_count++;
                end
                if (m_tdata[OUT_W-1:PAD_LSB] !== '0)
                begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[OUT_W-1:PAD_LSB]);
                    fail_count++;
                end
            end
        end
    end

    // give up after a long stretch with no transfer on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // offer one event, with random gaps before it, and predict at transfer
    task automatic send_event(input logic [FUNC_W-1:0] ev, input logic [RTT_W-1:0] rtt);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev;
        s_tdata  <= rtt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_reports.push_back(apply_event(ev, rtt));
    endtask

    // drop valid and wait until every predicted report has come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0)
            @(negedge clk);
    endtask

    // priority is only changed while the block is idle
    task automatic write_priority(input logic [PRIO_W-1:0] lvl);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        prio_now = lvl;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly realistic rtt values around the clamp points, some full range
    function automatic logic [RTT_W-1:0] pick_rtt();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 7);
            1, 2, 3: return $urandom_range(0, 300000);
            4, 5, 6, 7: return $urandom_range(150000, 5000000);
            default: return $urandom();
        endcase
    endfunction

    // acks dominate, losses keep the window small enough to grow in avoidance
    task automatic send_random_event();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 66)
            send_event(EV_ACK, $urandom());
        else if (pick < 77)
            send_event(EV_LOSS, $urandom());
        else if (pick < 95)
            send_event(EV_RTT, pick_rtt());
        else
            send_event(EV_NONE, $urandom());
    endtask

    task automatic run_random_events(input int count);
        repeat (count) send_random_event();
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // no event reports the reset state, rtt bits ignored
    task automatic test_reset_values();
        send_event(EV_NONE, 32'hFFFF_FFFF);
        send_event(EV_NONE, 32'h0000_0000);
    endtask

    // zero first samples, floor clamp, second sample path
    task automatic test_rtt_estimator();
        send_event(EV_RTT, 32'd0);
        send_event(EV_RTT, 32'd0);
        send_event(EV_RTT, 32'd1);
        send_event(EV_RTT, 32'd400000);
        send_event(EV_ACK, 32'hFFFF_FFFF);
    endtask

    // every priority code, timeout scaling seen on each
    task automatic test_priority_scaling();
        write_priority(PRIO_HIGH);
        send_event(EV_RTT, 32'd300000);
        write_priority(PRIO_CRIT);
        send_event(EV_RTT, 32'd300000);
        write_priority(PRIO_ALIAS);
        send_event(EV_RTT, 32'd300000);
        write_priority(PRIO_NORM);
        send_event(EV_RTT, 32'd300000);
    endtask

    // largest samples push the timeout to its ceiling
    task automatic test_timeout_ceiling();
        send_event(EV_RTT, 32'hFFFF_FFFF);
        send_event(EV_RTT, 32'hFFFF_FFFF);
    endtask

    // slow start is only ever seen after reset: ack until it ends
    task automatic test_slow_start_ramp();
        int pick;
        while (phase_now == PH_SLOW)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 92)
                send_event(EV_ACK, $urandom());
            else if (pick < 97)
                send_event(EV_RTT, pick_rtt());
            else
                send_event(EV_NONE, $urandom());
        end
    endtask

    // halving, recovery shrink, return to avoidance, floor at min window
    task automatic test_loss_recovery();
        send_event(EV_LOSS, $urandom());
        send_event(EV_LOSS, $urandom());
        send_event(EV_ACK, $urandom());
        send_event(EV_LOSS, $urandom());
        while (win_now > MIN_WIN)
            send_event(EV_LOSS, $urandom());
        send_event(EV_LOSS, $urandom());
        send_event(EV_ACK, $urandom());
        send_event(EV_LOSS, $urandom());
        send_event(EV_ACK, $urandom());
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_len = HOLD_OFF_CYCLES;
        hold_req_id = hold_req_id + 1;
        run_random_events(12);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver stalls heavily
        sender_idle_pct = 26;
        sink_stall_pct  = 80;
        test_reset_values();
        test_rtt_estimator();
        test_priority_scaling();
        test_timeout_ceiling();
        test_slow_start_ramp();

        // roles swapped
        wait_drained();
        sender_idle_pct = 80;
        sink_stall_pct  = 26;
        test_loss_recovery();
        write_priority(PRIO_CRIT);
        run_random_events(20);

        // no idling on either side
        wait_drained();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        write_priority(PRIO_HIGH);
        run_random_events(12);
        write_priority(PRIO_ALIAS);
        run_random_events(12);
        test_backpressure();
        write_priority(PRIO_NORM);
        run_random_events(10);

        wait_drained();
        repeat (DRAIN_TAIL) @(negedge clk);
        if (fail_count == 0 && due_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
